/* hw/rtl/pfa_pkg.sv */
// Page frame allocator: shared types and codes.
// Request/response payload structs, kind and status codes, controller states.
// No dependencies.
package pfa_pkg;

  localparam int FRAME_W  = 15;
  localparam int COUNT_W  = 8;
  localparam int FREE_W   = 16;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_ADD_REF = 2'd2,
    KIND_DROP    = 2'd3
  } pfa_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_OOM         = 3'd1,
    STAT_NOT_USABLE  = 3'd2,
    STAT_DOUBLE_FREE = 3'd3,
    STAT_SATURATED   = 3'd4
  } pfa_status_t;

  typedef struct packed {
    pfa_kind_t          kind;
    logic [FRAME_W-1:0] frame;
  } pfa_in_t;

  typedef struct packed {
    pfa_status_t        status;
    logic [FRAME_W-1:0] result_frame;
    logic [COUNT_W-1:0] ref_count;
    logic [FREE_W-1:0]  free_frames;
  } pfa_out_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } pfa_state_t;

endpackage

/* hw/rtl/pfa_ram.sv */
// Page frame allocator: single-port-write, single-port-read synchronous RAM.
// Read data is registered. No package dependency.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pfa_fill.sv */
// Page frame allocator: reset fill sweep over the count and stack memories.
// One frame per cycle after reset and after each first-usable-frame write.
// Depends on pfa_pkg.
module pfa_fill #(
  parameter int NUM_FRAMES = 32768,
  parameter int FW         = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pfa_pkg::FRAME_W-1:0] first_usable,
  output logic                        busy,
  output logic [FW-1:0]               cnt_addr,
  output logic                        cnt_below,
  output logic                        stk_we,
  output logic [FW-1:0]               stk_addr,
  output logic [FW-1:0]               stk_data
);
  import pfa_pkg::*;

  localparam logic [FW-1:0] LAST = FW'(NUM_FRAMES - 1);

  logic          busy_r;
  logic [FW-1:0] idx_r;
  logic [31:0]   idx32;
  logic [31:0]   fu32;
  logic [31:0]   rel32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r) begin
      if (idx_r == LAST) begin
        busy_r <= 1'b0;
      end
      idx_r <= idx_r + FW'(1);
    end
  end

  always_comb begin
    idx32     = 32'(idx_r);
    fu32      = 32'(first_usable);
    rel32     = idx32 - fu32;
    busy      = busy_r;
    cnt_addr  = idx_r;
    cnt_below = idx32 < fu32;
    stk_we    = busy_r && (idx32 >= fu32);
    stk_addr  = rel32[FW-1:0];
    stk_data  = idx_r;
  end

endmodule

/* hw/rtl/pfa_step.sv */
// Page frame allocator: decision logic for one request.
// Takes the read count and stack top, gives the response and the write-back.
// Depends on pfa_pkg.
module pfa_step #(
  parameter int NUM_FRAMES = 32768,
  parameter int MAX_REFS   = 255,
  parameter int FW         = 15,
  parameter int DW         = 16,
  parameter int CW         = 8
) (
  input  pfa_pkg::pfa_in_t            req,
  input  logic [pfa_pkg::FRAME_W-1:0] first_usable,
  input  logic [CW-1:0]               cnt,
  input  logic [FW-1:0]               top_frame,
  input  logic [DW-1:0]               depth,
  output pfa_pkg::pfa_out_t           rsp,
  output logic                        cnt_we,
  output logic [FW-1:0]               cnt_addr,
  output logic [CW-1:0]               cnt_wdata,
  output logic                        push,
  output logic [FW-1:0]               push_frame,
  output logic [DW-1:0]               depth_nxt
);
  import pfa_pkg::*;

  logic [31:0] f32;
  logic [31:0] fu32;
  logic [31:0] c32;
  logic [31:0] frame32;
  logic [31:0] count32;
  logic [31:0] depth32;
  pfa_status_t status;

  always_comb begin
    f32        = 32'(req.frame);
    fu32       = 32'(first_usable);
    c32        = 32'(cnt);
    frame32    = f32;
    count32    = c32;
    status     = STAT_OK;
    cnt_we     = 1'b0;
    cnt_addr   = f32[FW-1:0];
    cnt_wdata  = cnt;
    push       = 1'b0;
    push_frame = f32[FW-1:0];
    depth_nxt  = depth;
    priority if (req.kind == KIND_ALLOC) begin
      if (depth == '0) begin
        status  = STAT_OOM;
        frame32 = '0;
        count32 = '0;
      end else begin
        depth_nxt = depth - DW'(1);
        frame32   = 32'(top_frame);
        count32   = 32'd1;
        cnt_addr  = top_frame;
        cnt_we    = 1'b1;
        cnt_wdata = CW'(1);
      end
    end else if (f32 >= 32'(NUM_FRAMES)) begin
      status  = STAT_NOT_USABLE;
      count32 = '0;
    end else if (f32 < fu32) begin
      status = STAT_NOT_USABLE;
    end else begin
      unique case (req.kind)
        KIND_RELEASE: begin
          if (c32 == 32'd0) begin
            status = STAT_DOUBLE_FREE;
          end else if (c32 == 32'd1) begin
            cnt_we    = 1'b1;
            cnt_wdata = '0;
            count32   = '0;
            if (32'(depth) < 32'(NUM_FRAMES)) begin
              push      = 1'b1;
              depth_nxt = depth + DW'(1);
            end
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = CW'(c32 - 32'd1);
            count32   = c32 - 32'd1;
          end
        end
        KIND_ADD_REF: begin
          if (c32 == 32'd0) begin
            status = STAT_DOUBLE_FREE;
          end else if (c32 >= 32'(MAX_REFS)) begin
            status = STAT_SATURATED;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = CW'(c32 + 32'd1);
            count32   = c32 + 32'd1;
          end
        end
        KIND_DROP: begin
          if (c32 <= 32'd1) begin
            status = STAT_DOUBLE_FREE;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = CW'(c32 - 32'd1);
            count32   = c32 - 32'd1;
          end
        end
        KIND_ALLOC: begin
        end
      endcase
    end
    depth32          = 32'(depth_nxt);
    rsp.status       = status;
    rsp.result_frame = frame32[FRAME_W-1:0];
    rsp.ref_count    = count32[COUNT_W-1:0];
    rsp.free_frames  = depth32[FREE_W-1:0];
  end

endmodule

/* hw/rtl/page_frame_allocator_refcount_unit.sv */
// Page frame allocator with LIFO free stack and per-frame reference counts.
// Top level: controller, output register, count and stack memories.
// Depends on pfa_pkg, pfa_ram, pfa_fill, pfa_step.
//
//   channel  ports                          direction  transfer
//   request  in_valid/in_ready/in_req       in         valid & ready
//   response out_valid/out_ready/out_rsp    out        valid & ready
//   config   cfg_we/cfg_wdata               in         cfg_we, no wait
//
// Each request is accepted in IDLE, which issues the reads of both memories;
// in EXEC it is decided from the registered read data and written back.
// After reset and after every cfg write a fill sweep runs over all
// NUM_FRAMES frames; no request is accepted until it ends.
// A request whose response finds the output register still full waits in
// the execute cycle until out_ready frees it.
module page_frame_allocator_refcount_unit #(
  parameter int NUM_FRAMES = 32768,
  parameter int MAX_REFS   = 255
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pfa_pkg::pfa_in_t            in_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pfa_pkg::pfa_out_t           out_rsp,
  input  logic                        cfg_we,
  input  logic [pfa_pkg::FRAME_W-1:0] cfg_wdata
);
  import pfa_pkg::*;

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int DW = $clog2(NUM_FRAMES + 1);
  localparam int CW = $clog2(MAX_REFS + 1);
  localparam logic [DW-1:0] NF_D = DW'(NUM_FRAMES);

  pfa_state_t         state_r, state_nxt;
  pfa_in_t            req_r;
  logic [FRAME_W-1:0] fu_r;
  logic [DW-1:0]      depth_r;
  logic [DW-1:0]      depth_fill;
  logic [DW-1:0]      depth_dec;
  logic               out_valid_r;
  pfa_out_t           out_rsp_r;
  logic               in_fire;
  logic               commit;
  logic [31:0]        in_f32;
  logic [31:0]        cfg32;

  logic               fill_busy;
  logic [FW-1:0]      fill_cnt_addr;
  logic               fill_below;
  logic               fill_stk_we;
  logic [FW-1:0]      fill_stk_addr;
  logic [FW-1:0]      fill_stk_data;

  pfa_out_t           step_rsp;
  logic               step_cnt_we;
  logic [FW-1:0]      step_cnt_addr;
  logic [CW-1:0]      step_cnt_wdata;
  logic               step_push;
  logic [FW-1:0]      step_push_frame;
  logic [DW-1:0]      step_depth_nxt;

  logic               cnt_we;
  logic [FW-1:0]      cnt_waddr;
  logic [CW-1:0]      cnt_wdata;
  logic [CW-1:0]      cnt_rdata;
  logic               stk_we;
  logic [FW-1:0]      stk_waddr;
  logic [FW-1:0]      stk_wdata;
  logic [FW-1:0]      stk_rdata;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !fill_busy;
        if (in_valid && !fill_busy) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        commit = !fill_busy && (!out_valid_r || out_ready);
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  assign in_fire   = in_valid && in_ready;
  assign in_f32    = 32'(in_req.frame);
  assign cfg32     = 32'(cfg_wdata);
  assign depth_dec = depth_r - DW'(1);
  assign depth_fill = (cfg32 >= 32'(NUM_FRAMES)) ? '0
                    : DW'(32'(NUM_FRAMES) - cfg32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      fu_r        <= '0;
      depth_r     <= NF_D;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        fu_r <= cfg_wdata;
      end
      priority if (cfg_we) begin
        depth_r <= depth_fill;
      end else if (commit) begin
        depth_r <= step_depth_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_req;
    end
    if (commit) begin
      out_rsp_r <= step_rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  pfa_fill #(
    .NUM_FRAMES(NUM_FRAMES),
    .FW        (FW)
  ) u_fill (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (cfg_we),
    .first_usable(fu_r),
    .busy        (fill_busy),
    .cnt_addr    (fill_cnt_addr),
    .cnt_below   (fill_below),
    .stk_we      (fill_stk_we),
    .stk_addr    (fill_stk_addr),
    .stk_data    (fill_stk_data)
  );

  pfa_step #(
    .NUM_FRAMES(NUM_FRAMES),
    .MAX_REFS  (MAX_REFS),
    .FW        (FW),
    .DW        (DW),
    .CW        (CW)
  ) u_step (
    .req         (req_r),
    .first_usable(fu_r),
    .cnt         (cnt_rdata),
    .top_frame   (stk_rdata),
    .depth       (depth_r),
    .rsp         (step_rsp),
    .cnt_we      (step_cnt_we),
    .cnt_addr    (step_cnt_addr),
    .cnt_wdata   (step_cnt_wdata),
    .push        (step_push),
    .push_frame  (step_push_frame),
    .depth_nxt   (step_depth_nxt)
  );

  always_comb begin
    if (fill_busy) begin
      cnt_we    = 1'b1;
      cnt_waddr = fill_cnt_addr;
      cnt_wdata = CW'(fill_below);
      stk_we    = fill_stk_we;
      stk_waddr = fill_stk_addr;
      stk_wdata = fill_stk_data;
    end else begin
      cnt_we    = commit && step_cnt_we;
      cnt_waddr = step_cnt_addr;
      cnt_wdata = step_cnt_wdata;
      stk_we    = commit && step_push;
      stk_waddr = depth_r[FW-1:0];
      stk_wdata = step_push_frame;
    end
  end

  pfa_ram #(
    .WIDTH(CW),
    .DEPTH(NUM_FRAMES),
    .AW   (FW)
  ) u_count_mem (
    .clk    (clk),
    .we     (cnt_we),
    .waddr  (cnt_waddr),
    .wdata  (cnt_wdata),
    .re     (in_fire),
    .raddr  (in_f32[FW-1:0]),
    .rdata_r(cnt_rdata)
  );

  pfa_ram #(
    .WIDTH(FW),
    .DEPTH(NUM_FRAMES),
    .AW   (FW)
  ) u_stack_mem (
    .clk    (clk),
    .we     (stk_we),
    .waddr  (stk_waddr),
    .wdata  (stk_wdata),
    .re     (in_fire),
    .raddr  (depth_dec[FW-1:0]),
    .rdata_r(stk_rdata)
  );

  a_no_commit_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_busy |-> !commit)
    else $error("request committed during fill sweep");

  a_depth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= NF_D)
    else $error("free stack depth above frame count");

  a_alloc_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (req_r.kind == KIND_ALLOC) && (depth_r != '0) |=>
      out_valid_r && (out_rsp_r.status == STAT_OK) && (out_rsp_r.ref_count == 8'd1))
    else $error("successful allocate did not report count one");

  a_depth_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !commit && !cfg_we |=> $stable(depth_r))
    else $error("free stack depth changed without a request or cfg write");

endmodule

/* sim/page_frame_allocator_refcount_unit_test.sv */
// Self-checking testbench for page_frame_allocator_refcount_unit.
// A frame ledger class predicts every response, and plain tasks drive requests,
// configuration writes and random stalls. Depends on pfa_pkg and the unit RTL.
`timescale 1ns / 1ps

module page_frame_allocator_refcount_unit_test;
  import pfa_pkg::*;

  localparam int NUM_FRAMES = 32768;
  localparam int MAX_REFS   = 255;

  class frame_ledger;
    logic [COUNT_W-1:0] ref_counts [NUM_FRAMES];
    logic [FRAME_W-1:0] free_stack [NUM_FRAMES];
    int                 depth;
    int                 first_usable;
    pfa_out_t           expected [$];
    int                 errors;

    function new();
      errors = 0;
      configure(0);
    endfunction

    function void configure(int value);
      depth = 0;
      first_usable = value;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (i < value) begin
          ref_counts[i] = 1;
        end else begin
          ref_counts[i] = 0;
          free_stack[depth] = FRAME_W'(i);
          depth++;
        end
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function pfa_out_t note_request(pfa_in_t req);
      pfa_out_t r;
      int       f;
      int       c;
      f = req.frame;
      r.status = STAT_OK;
      r.result_frame = req.frame;
      r.ref_count = '0;
      if (req.kind == KIND_ALLOC) begin
        if (depth == 0) begin
          r.status = STAT_OOM;
          r.result_frame = '0;
        end else begin
          depth--;
          r.result_frame = free_stack[depth];
          ref_counts[free_stack[depth]] = 1;
          r.ref_count = 1;
        end
      end else begin
        c = ref_counts[f];
        r.ref_count = COUNT_W'(c);
        if (f < first_usable) begin
          r.status = STAT_NOT_USABLE;
        end else begin
          case (req.kind)
            KIND_RELEASE: begin
              if (c == 0) begin
                r.status = STAT_DOUBLE_FREE;
              end else if (c == 1) begin
                ref_counts[f] = 0;
                r.ref_count = 0;
                if (depth < NUM_FRAMES) begin
                  free_stack[depth] = req.frame;
                  depth++;
                end
              end else begin
                ref_counts[f] = COUNT_W'(c - 1);
                r.ref_count = COUNT_W'(c - 1);
              end
            end
            KIND_ADD_REF: begin
              if (c == 0) begin
                r.status = STAT_DOUBLE_FREE;
              end else if (c >= MAX_REFS) begin
                r.status = STAT_SATURATED;
              end else begin
                ref_counts[f] = COUNT_W'(c + 1);
                r.ref_count = COUNT_W'(c + 1);
              end
            end
            KIND_DROP: begin
              if (c <= 1) begin
                r.status = STAT_DOUBLE_FREE;
              end else begin
                ref_counts[f] = COUNT_W'(c - 1);
                r.ref_count = COUNT_W'(c - 1);
              end
            end
          endcase
        end
      end
      r.free_frames = FREE_W'(depth);
      expected.push_back(r);
      return r;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_response(pfa_out_t got);
      pfa_out_t want;
      if (expected.size() == 0) begin
        report($sformatf("response with none pending: status %0d frame %0d count %0d free %0d",
                         got.status, got.result_frame, got.ref_count, got.free_frames));
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status || got.result_frame !== want.result_frame ||
          got.ref_count !== want.ref_count || got.free_frames !== want.free_frames) begin
        report($sformatf("status %0d/%0d frame %0d/%0d count %0d/%0d free %0d/%0d (got/want)",
                         got.status, want.status, got.result_frame, want.result_frame,
                         got.ref_count, want.ref_count, got.free_frames, want.free_frames));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  pfa_in_t            in_req;
  logic               out_valid;
  logic               out_ready;
  pfa_out_t           out_rsp;
  logic               cfg_we;
  logic [FRAME_W-1:0] cfg_wdata;

  frame_ledger        ledger = new();
  logic [FRAME_W-1:0] held [$];
  bit                 idle_on = 1'b1;
  int                 stall_left = 0;

  page_frame_allocator_refcount_unit #(
    .NUM_FRAMES(NUM_FRAMES),
    .MAX_REFS  (MAX_REFS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      ledger.check_response(out_rsp);
    end
  end

  function void forget_frame(logic [FRAME_W-1:0] frame);
    for (int i = 0; i < held.size(); i++) begin
      if (held[i] == frame) begin
        held.delete(i);
        return;
      end
    end
  endfunction

  task automatic send(pfa_kind_t kind, logic [FRAME_W-1:0] frame);
    pfa_in_t  req;
    pfa_out_t want;
    req.kind = kind;
    req.frame = frame;
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = ledger.note_request(req);
    if (kind == KIND_ALLOC && want.status == STAT_OK) begin
      held.push_back(want.result_frame);
    end else if (kind == KIND_RELEASE && want.status == STAT_OK && want.ref_count == 0) begin
      forget_frame(frame);
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_first_usable(logic [FRAME_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.configure(value);
    held.delete();
  endtask

  function logic [FRAME_W-1:0] any_frame();
    return FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
  endfunction

  task automatic random_requests(int count);
    int                 pick;
    logic [FRAME_W-1:0] frame;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
        frame = any_frame();
        if (ledger.first_usable > 0 && $urandom_range(0, 1) == 0) begin
          frame = FRAME_W'($urandom_range(0, ledger.first_usable - 1));
        end
        send(pfa_kind_t'($urandom_range(0, 3)), frame);
      end else if (held.size() == 0 || pick < 35) begin
        send(KIND_ALLOC, any_frame());
      end else begin
        frame = held[$urandom_range(0, held.size() - 1)];
        if (pick < 60) begin
          send(KIND_RELEASE, frame);
        end else if (pick < 75) begin
          send(KIND_ADD_REF, frame);
        end else begin
          send(KIND_DROP, frame);
        end
      end
      if ($urandom_range(0, 199) == 0) begin
        wait_drained();
      end
    end
  endtask

  task automatic climb_and_fall();
    logic [FRAME_W-1:0] frame;
    send(KIND_ALLOC, any_frame());
    frame = held[held.size() - 1];
    repeat (MAX_REFS + 3) send(KIND_ADD_REF, frame);
    repeat (MAX_REFS + 1) send(KIND_DROP, frame);
    send(KIND_RELEASE, frame);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    climb_and_fall();
    random_requests(300);

    write_first_usable(15'd32766);
    send(KIND_ALLOC, 15'd0);
    send(KIND_ALLOC, 15'h7FFF);
    send(KIND_ALLOC, 15'd0);
    send(KIND_ADD_REF, 15'd32767);
    send(KIND_RELEASE, 15'd32767);
    send(KIND_DROP, 15'd32767);
    send(KIND_ADD_REF, 15'd32767);
    send(KIND_DROP, 15'd32767);
    send(KIND_RELEASE, 15'd32767);
    send(KIND_RELEASE, 15'd32767);
    send(KIND_ADD_REF, 15'd32767);
    send(KIND_DROP, 15'd32767);
    send(KIND_RELEASE, 15'd0);
    send(KIND_ADD_REF, 15'd32765);
    send(KIND_DROP, 15'd16383);
    send(KIND_RELEASE, 15'd32766);
    send(KIND_ALLOC, 15'h7FFF);
    send(KIND_ALLOC, 15'h5555);
    send(KIND_ALLOC, 15'h2AAA);
    random_requests(200);

    write_first_usable(15'd32767);
    random_requests(200);

    write_first_usable(15'd32760);
    random_requests(200);

    write_first_usable(15'd32700);
    random_requests(200);

    write_first_usable(15'd0);
    idle_on = 1'b0;
    random_requests(250);

    wait_drained();
    repeat (16) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("page_frame_allocator_refcount_unit regression: pass");
    end else begin
      $display("page_frame_allocator_refcount_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("page_frame_allocator_refcount_unit regression: fail");
    $finish;
  end

endmodule
